[hw/rtl/jets_pkg.sv]
// Shared types, constants and helpers for the Julia escape-time pixel engine.
package jets_pkg;

  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 8;

  localparam int XY_W     = 32;
  localparam int WIDE_W   = 2 * XY_W;
  localparam int PITCH_W  = 31;
  localparam int PC_W     = PITCH_W + COORD_BITS;
  localparam int HUE_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HUE_W:0] HUE_STEP = (HUE_W + 1)'(1 << 5);
  localparam logic [HUE_W:0] HUE_MOD  = (HUE_W + 1)'(360);

  localparam logic [WIDE_W-1:0] MAG_FOUR = WIDE_W'(4) << FRAC_BITS;

  localparam logic signed [WIDE_W-1:0] XY_HI = (64'sd1 <<< (XY_W - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] XY_LO = -(64'sd1 <<< (XY_W - 1));

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_REAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_IMAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd5;

  localparam logic signed [XY_W-1:0] RST_C_REAL     = -32'sd201326592;
  localparam logic signed [XY_W-1:0] RST_C_IMAG     = 32'sd0;
  localparam logic signed [XY_W-1:0] RST_START_REAL = -32'sd429496730;
  localparam logic signed [XY_W-1:0] RST_START_IMAG = 32'sd322122547;
  localparam logic [PITCH_W-1:0]     RST_PITCH      = 31'd715828;
  localparam logic [COUNT_BITS-1:0]  RST_LIMIT      = COUNT_BITS'(180);

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] iter_count;
    logic                  inside_set;
    logic [HUE_W-1:0]      hue_degrees;
  } result_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [XY_W-1:0] c_real;
    logic signed [XY_W-1:0] c_imag;
    logic signed [XY_W-1:0] start_real;
    logic signed [XY_W-1:0] start_imag;
    logic [PITCH_W-1:0]     pixel_pitch;
    logic [COUNT_BITS-1:0]  iteration_limit;
  } cfg_t;

  // clamp a wide signed value to the coordinate range
  function automatic logic signed [XY_W-1:0] sat_xy(input logic signed [WIDE_W-1:0] v);
    logic signed [XY_W-1:0] r;
    if (v > XY_HI) begin
      r = XY_HI[XY_W-1:0];
    end else if (v < XY_LO) begin
      r = XY_LO[XY_W-1:0];
    end else begin
      r = v[XY_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/jets_cfg.sv]
// Configuration register file for the escape-time engine.
module jets_cfg import jets_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_real          <= RST_C_REAL;
      cfg.c_imag          <= RST_C_IMAG;
      cfg.start_real      <= RST_START_REAL;
      cfg.start_imag      <= RST_START_IMAG;
      cfg.pixel_pitch     <= RST_PITCH;
      cfg.iteration_limit <= RST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_C_REAL:     cfg.c_real          <= cfg_data[XY_W-1:0];
        REG_C_IMAG:     cfg.c_imag          <= cfg_data[XY_W-1:0];
        REG_START_REAL: cfg.start_real      <= cfg_data[XY_W-1:0];
        REG_START_IMAG: cfg.start_imag      <= cfg_data[XY_W-1:0];
        REG_PITCH:      cfg.pixel_pitch     <= cfg_data[PITCH_W-1:0];
        REG_LIMIT:      cfg.iteration_limit <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/jets_front.sv]
// Front end: accept pixels and map them to their starting points.
module jets_front import jets_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   pixel_valid,
  output logic   pixel_stall,
  input  pixel_t pixel,
  output logic   push,
  input  logic   push_ready,
  output point_t point
);

  logic            s1_valid;
  logic [PC_W-1:0] pc_col;
  logic [PC_W-1:0] pc_row;
  logic            s2_valid;
  logic            s1_adv;
  logic            s2_adv;

  assign push        = s2_valid;
  assign s2_adv      = !s2_valid || push_ready;
  assign s1_adv      = !s1_valid || s2_adv;
  assign pixel_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= pixel_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // offsets along each axis
  always_ff @(posedge clk) begin
    if (s1_adv && pixel_valid) begin
      pc_col <= cfg.pixel_pitch * pixel.column;
      pc_row <= cfg.pixel_pitch * pixel.row;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      point.x <= sat_xy(WIDE_W'($signed(cfg.start_real)) + $signed(WIDE_W'(pc_col)));
      point.y <= sat_xy(WIDE_W'($signed(cfg.start_imag)) - $signed(WIDE_W'(pc_row)));
    end
  end

endmodule

[hw/rtl/jets_queue.sv]
// Short queue of starting points between front end and iteration engine.
module jets_queue import jets_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   push_ready,
  input  point_t push_point,
  output logic   pop_valid,
  input  logic   pop,
  output point_t pop_point
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  point_t           entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_point  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_point;
    end
  end

endmodule

[hw/rtl/jets_back.sv]
// Iteration engine: run z = z*z + c and deliver the escape result.
module jets_back import jets_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    pop_valid,
  output logic    pop,
  input  point_t  pop_point,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]               state;
  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [WIDE_W-1:0] prod_xx;
  logic signed [WIDE_W-1:0] prod_yy;
  logic signed [WIDE_W-1:0] prod_xy;
  logic [COUNT_BITS-1:0]    k;
  logic [COUNT_BITS-1:0]    k_next;
  logic [HUE_W-1:0]         hue;
  logic [HUE_W-1:0]         hue_next;
  logic [HUE_W:0]           hue_sum;
  logic                     first;
  logic                     in_set;
  logic signed [WIDE_W-1:0] diff;
  logic signed [WIDE_W-1:0] re_w;
  logic signed [WIDE_W-1:0] im_w;
  logic [WIDE_W-1:0]        mag_sum;
  logic                     escape;
  logic                     out_free;

  assign pop      = (state == ST_IDLE) && pop_valid;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    diff    = prod_xx - prod_yy;
    re_w    = (diff >>> FRAC_BITS) + WIDE_W'($signed(cfg.c_real));
    im_w    = (prod_xy >>> (FRAC_BITS - 1)) + WIDE_W'($signed(cfg.c_imag));
    mag_sum = $unsigned(prod_xx) + $unsigned(prod_yy);
    escape  = !first && ((mag_sum >> FRAC_BITS) > MAG_FOUR);
    k_next  = k + 1'b1;
    hue_sum = {1'b0, hue} + HUE_STEP;
    hue_next = (hue_sum >= HUE_MOD) ? HUE_W'(hue_sum - HUE_MOD) : hue_sum[HUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= (cfg.iteration_limit == '0) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: state <= ST_ADD;
        ST_ADD: begin
          if (escape || (!first && (k_next == cfg.iteration_limit))) begin
            state <= ST_FIN;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x      <= pop_point.x;
        y      <= pop_point.y;
        k      <= '0;
        hue    <= '0;
        first  <= 1'b1;
        in_set <= 1'b1;
      end
      ST_MUL: begin
        prod_xx <= x * x;
        prod_yy <= y * y;
        prod_xy <= x * y;
      end
      ST_ADD: begin
        x     <= sat_xy(re_w);
        y     <= sat_xy(im_w);
        first <= 1'b0;
        if (escape) begin
          in_set <= 1'b0;
        end else if (!first) begin
          k   <= k_next;
          hue <= hue_next;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          result.iter_count  <= k;
          result.inside_set  <= in_set;
          result.hue_degrees <= hue;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/julia_escape_time_pixel_top.sv]
// Top level of the Julia set escape-time pixel engine.
// One pixel (column, row) gives one result: the escape iteration index, an
// in-set flag and the hue (count << 5) mod 360. The start point and every
// new z are signed Q4.28, saturated to 32 bits; squares are truncated
// towards minus infinity. In the iteration engine each iteration is a
// multiply step for x*x, y*y and x*y followed by an add, saturate and
// magnitude-compare step through the same datapath. The front end maps
// pixels to start points in a multiply stage and an add-and-saturate stage
// and parks them in a two-entry queue, so new pixels are taken, until the
// queue fills, while the engine iterates and while a finished result waits
// in the output register. Write configuration only while idle.
module julia_escape_time_pixel_top import jets_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  output logic                  pixel_stall,
  input  pixel_t                pixel,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   push;
  logic   push_ready;
  point_t push_point;
  logic   pop_valid;
  logic   pop;
  point_t pop_point;

  // hold register values written through the configuration port
  jets_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // map each transfer on the pixel channel to its start point
  jets_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .push        (push),
    .push_ready  (push_ready),
    .point       (push_point)
  );

  // decouple the mapping pipeline from the iteration engine
  jets_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_point (push_point),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_point  (pop_point)
  );

  // iterate one point at a time and present its result for transfer
  jets_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_point    (pop_point),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[test/tb.sv]
// Self-checking testbench for the Julia escape-time pixel engine top level.
`timescale 1ns / 100ps

module tb;
  import jets_pkg::*;

  // Generous ceiling on the run length of this stimulus: every pixel at its limit,
  // with every gap and stall at its longest, still ends well inside this.
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_PIXELS = 1850;
  localparam int MAX_WAIT      = 6;
  localparam int TAIL_CYCLES   = 20;

  // Indexes past the last register: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

  // One row of the directed table: either a register write or a pixel,
  // the pixel optionally carrying a result known by inspection.
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    pixel_t                pix;
    bit                    known;
    result_t               want;
  } plan_row_t;

  // Travels with each pixel from the driver to the point of transfer.
  typedef struct packed {
    logic    known;
    result_t want;
  } pixel_tag_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  pixel_valid  = 1'b0;
  logic                  pixel_stall;
  pixel_t                pixel        = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  cfg_t       view;                 // our copy of the register file
  plan_row_t  plan[$];
  pixel_tag_t pixel_tags[$];        // pixels driven but not yet transferred
  result_t    expected_results[$];  // escape results still owed by the block

  int errors, pixels_sent, settings_used, n_escaped, n_inside;
  int hold_left, cycle_count;
  bit send_gaps, recv_stalls;

  // Well-known Julia constants in Q4.28: they give the richest boundaries.
  int julia_re[7] = '{-201326592, -214748365, 76504106, -107374182,
                      -188378247, 95294587, -224143606};
  int julia_im[7] = '{0, 41875931, 2684355, 161061274,
                      -103132902, 95294587, -62303869};

  julia_escape_time_pixel_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Clamp to the signed 32-bit coordinate range.
  function automatic longint clamp_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Escape-time prediction for one pixel under the current register copy.
  // Squares are floored to Q.28, the cross term to Q.27 (that is 2xy in
  // Q.28), and the escape test is on the new z, before the count advances.
  function automatic result_t predict_escape(pixel_t p);
    longint      x, y, nx, ny;
    logic [63:0] mag;
    int          k;
    result_t     r;
    x = clamp_q(longint'($signed(view.start_real))
                + longint'(view.pixel_pitch) * longint'(p.column));
    y = clamp_q(longint'($signed(view.start_imag))
                - longint'(view.pixel_pitch) * longint'(p.row));
    k = 0;
    while (k < int'(view.iteration_limit)) begin
      nx  = clamp_q(((x * x - y * y) >>> FRAC_BITS) + longint'($signed(view.c_real)));
      ny  = clamp_q(((x * y) >>> (FRAC_BITS - 1)) + longint'($signed(view.c_imag)));
      mag = ($unsigned(nx * nx) + $unsigned(ny * ny)) >> FRAC_BITS;
      x   = nx;
      y   = ny;
      if (mag > MAG_FOUR) break;
      k++;
    end
    r.iter_count  = k[COUNT_BITS-1:0];
    r.inside_set  = (k >= int'(view.iteration_limit));
    r.hue_degrees = HUE_W'((k << 5) % 360);
    return r;
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r          = '{default: '0};
    r.is_write = 1'b1;
    r.index    = idx;
    r.data     = data;
    plan.push_back(r);
  endfunction

  function automatic void plan_pixel(int col, int row);
    plan_row_t r;
    r            = '{default: '0};
    r.pix.column = COORD_BITS'(col);
    r.pix.row    = COORD_BITS'(row);
    plan.push_back(r);
  endfunction

  function automatic void plan_known(int col, int row, int iters, bit in_set, int hue);
    plan_row_t r;
    r                  = '{default: '0};
    r.pix.column       = COORD_BITS'(col);
    r.pix.row          = COORD_BITS'(row);
    r.known            = 1'b1;
    r.want.iter_count  = COUNT_BITS'(iters);
    r.want.inside_set  = in_set;
    r.want.hue_degrees = HUE_W'(hue);
    plan.push_back(r);
  endfunction

  // Drive one pixel and hold it until it transfers. Valid is left high on
  // return, so a back-to-back pixel never drops and raises it in one step.
  task automatic send_pixel(pixel_t p, bit known, result_t want);
    int gap;
    gap = send_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    pixel_tags.push_back('{known, want});
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid and hold off until every owed result has transferred.
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pixel_tags.size() != 0 || expected_results.size() != 0);
  endtask

  // One register write; valid stays high for the next write of a batch and
  // the caller drops it after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_C_REAL:     view.c_real          = data;
      REG_C_IMAG:     view.c_imag          = data;
      REG_START_REAL: view.start_real      = data;
      REG_START_IMAG: view.start_imag      = data;
      REG_PITCH:      view.pixel_pitch     = data[PITCH_W-1:0];
      REG_LIMIT:      view.iteration_limit = data[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Receive side: on each pixel transfer queue its typed or predicted result,
  // check each result transfer against the oldest one queued, and draw a fresh
  // stall after every result transfer.
  always @(posedge clk) begin
    pixel_tag_t tag;
    result_t    want;
    int         hold;
    if (rst) begin
      hold_left    <= 0;
      result_stall <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        tag = pixel_tags.pop_front();
        expected_results.push_back(tag.known ? tag.want : predict_escape(pixel));
      end
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: iter_count %0d inside_set %0d hue_degrees %0d",
                 result.iter_count, result.inside_set, result.hue_degrees);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.iter_count !== want.iter_count) begin
            $error("iter_count: expected %0d, got %0d", want.iter_count, result.iter_count);
            errors++;
          end
          if (result.inside_set !== want.inside_set) begin
            $error("inside_set: expected %0d, got %0d", want.inside_set, result.inside_set);
            errors++;
          end
          if (result.hue_degrees !== want.hue_degrees) begin
            $error("hue_degrees: expected %0d, got %0d", want.hue_degrees,
                   result.hue_degrees);
            errors++;
          end
          if (want.inside_set) n_inside++;
          else n_escaped++;
        end
        hold = recv_stalls ? $urandom_range(0, MAX_WAIT) : 0;
        hold_left    <= hold;
        result_stall <= (hold != 0);
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        result_stall <= (hold_left > 1);
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] vals[6];
    int     kind, lim, n_items, col_top, row_top, k, rot, goal;
    bit     writing;
    pixel_t p;

    view = '{RST_C_REAL, RST_C_IMAG, RST_START_REAL, RST_START_IMAG, RST_PITCH, RST_LIMIT};

    // Directed table. Rows with a typed result are ones whose answer is plain
    // by inspection; the rest go through the predictor.
    // Reset view: the top-left corner leaves the disc on the first step.
    plan_known(0, 0, 0, 0, 0);
    plan_pixel(600, 400);
    plan_pixel(2047, 2047);
    // Zero limit, with junk in the upper data bits: no iteration runs.
    plan_write(REG_LIMIT, 32'hFFFF_FF00);
    plan_known(0, 0, 0, 1, 0);
    plan_known(2047, 0, 0, 1, 0);
    // Origin with c = 0 never moves: inside at the limit, hue from the count.
    plan_write(REG_C_REAL, 32'h0);
    plan_write(REG_C_IMAG, 32'h0);
    plan_write(REG_START_REAL, 32'h0);
    plan_write(REG_START_IMAG, 32'h0);
    plan_write(REG_PITCH, 32'h8000_0000);
    plan_write(REG_LIMIT, 32'd1);
    plan_known(1234, 567, 1, 1, 32);
    plan_write(REG_LIMIT, 32'd255);
    plan_known(2047, 2047, 255, 1, 240);
    // Start points at the edges of the coordinate range escape at once.
    plan_write(REG_START_REAL, 32'h7FFF_FFFF);
    plan_write(REG_START_IMAG, 32'h8000_0000);
    plan_write(REG_LIMIT, 32'd9);
    plan_known(0, 0, 0, 0, 0);
    // Widest pitch: the far corner's start point saturates on both axes.
    plan_write(REG_PITCH, 32'h7FFF_FFFF);
    plan_write(REG_START_REAL, 32'h8000_0000);
    plan_write(REG_START_IMAG, 32'h7FFF_FFFF);
    plan_known(2047, 2047, 0, 0, 0);
    plan_known(1, 0, 0, 0, 0);
    // Extreme c: the first new z is far outside.
    plan_write(REG_C_REAL, 32'h8000_0000);
    plan_write(REG_C_IMAG, 32'h7FFF_FFFF);
    plan_write(REG_START_REAL, 32'h0);
    plan_write(REG_START_IMAG, 32'h0);
    plan_write(REG_PITCH, 32'd1);
    plan_write(REG_LIMIT, 32'd255);
    plan_known(0, 0, 0, 0, 0);
    plan_known(2047, 2047, 0, 0, 0);
    // Writes to unused indexes must not disturb a fixed point at the origin;
    // twelve steps also wrap the hue past 360.
    plan_write(REG_C_REAL, 32'h0);
    plan_write(REG_C_IMAG, 32'h0);
    plan_write(REG_PITCH, 32'h0);
    plan_write(REG_LIMIT, 32'd12);
    plan_write(REG_UNUSED_A, 32'h7FFF_FFFF);
    plan_write(REG_UNUSED_B, 32'h7FFF_FFFF);
    plan_known(5, 5, 12, 1, 24);
    // Classic constants over the reset view.
    plan_write(REG_C_REAL, -32'sd214748365);
    plan_write(REG_C_IMAG, 32'sd41875931);
    plan_write(REG_START_REAL, RST_START_REAL);
    plan_write(REG_START_IMAG, RST_START_IMAG);
    plan_write(REG_PITCH, 32'(RST_PITCH));
    plan_write(REG_LIMIT, 32'd60);
    plan_pixel(600, 450);
    plan_pixel(300, 200);
    plan_pixel(900, 700);
    plan_pixel(1199, 899);
    plan_write(REG_C_REAL, 32'sd76504106);
    plan_write(REG_C_IMAG, 32'sd2684355);
    plan_write(REG_LIMIT, 32'd255);
    plan_pixel(600, 400);
    plan_pixel(610, 410);
    plan_pixel(0, 899);

    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table. Before the first write of a batch, drain the block so
    // that registers only ever change while it is idle.
    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!writing) begin
          wait_idle();
          writing = 1'b1;
        end
        write_reg(plan[i].index, plan[i].data);
      end else begin
        if (writing) begin
          cfg_valid <= 1'b0;
          writing = 1'b0;
          settings_used++;
        end
        send_pixel(plan[i].pix, 1'b0 | plan[i].known, plan[i].want);
      end
    end

    // Random phases: each drains the block, writes every register in a
    // rotated order, then streams a batch of pixels through the new setting.
    goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < goal) begin
      wait_idle();
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // Around the reset view, with a known constant or one near the origin.
        k = $urandom_range(0, 6);
        if ($urandom_range(0, 2) == 0) begin
          vals[REG_C_REAL] = $urandom_range(0, 1 << 29) - (1 << 28);
          vals[REG_C_IMAG] = $urandom_range(0, 1 << 29) - (1 << 28);
        end else begin
          vals[REG_C_REAL] = julia_re[k];
          vals[REG_C_IMAG] = julia_im[k];
        end
        vals[REG_START_REAL] = RST_START_REAL + ($urandom_range(0, 1 << 26) - (1 << 25));
        vals[REG_START_IMAG] = RST_START_IMAG + ($urandom_range(0, 1 << 26) - (1 << 25));
        vals[REG_PITCH]      = {1'($urandom), 31'($urandom_range(200000, 1500000))};
        col_top = 1199;
        row_top = 899;
      end else if (kind < 8) begin
        // Zoomed in somewhere on the plane, fine pitch.
        vals[REG_C_REAL]     = $urandom_range(0, 1 << 29) - (1 << 28);
        vals[REG_C_IMAG]     = $urandom_range(0, 1 << 29) - (1 << 28);
        vals[REG_START_REAL] = $urandom_range(0, 1 << 30) - (1 << 29);
        vals[REG_START_IMAG] = $urandom_range(0, 1 << 30) - (1 << 29);
        vals[REG_PITCH]      = {1'($urandom), 31'($urandom_range(0, 1 << 18))};
        col_top = 2047;
        row_top = 2047;
      end else begin
        // Anything goes: saturation and instant escape dominate.
        vals[REG_C_REAL]     = $urandom;
        vals[REG_C_IMAG]     = $urandom;
        vals[REG_START_REAL] = $urandom;
        vals[REG_START_IMAG] = $urandom;
        vals[REG_PITCH]      = $urandom;
        col_top = 2047;
        row_top = 2047;
      end
      // Mostly short limits to keep the run brisk; now and then the extremes.
      k = $urandom_range(0, 11);
      if (k == 0) lim = 255;
      else if (k == 1) lim = 1;
      else if (k == 2) lim = 0;
      else lim = $urandom_range(2, 48);
      vals[REG_LIMIT] = {24'($urandom), 8'(lim)};

      rot = $urandom_range(0, 5);
      for (k = 0; k <= int'(REG_LIMIT); k++) begin
        write_reg(CFG_IDX_W'((k + rot) % (int'(REG_LIMIT) + 1)),
                  vals[(k + rot) % (int'(REG_LIMIT) + 1)]);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom);
      end
      cfg_valid <= 1'b0;
      settings_used++;

      // Some phases run flat out on one side or both.
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      n_items     = (lim == 255) ? 20 : $urandom_range(60, 200);
      if (n_items > goal - pixels_sent) n_items = goal - pixels_sent;
      for (k = 0; k < n_items; k++) begin
        p.column = $urandom_range(0, col_top);
        p.row    = $urandom_range(0, row_top);
        send_pixel(p, 1'b0, '0);
        // Occasionally let the pipeline run dry mid-phase.
        if ($urandom_range(0, 99) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d pixels over %0d register settings", pixels_sent, settings_used);
    $display("of which %0d escaped and %0d stayed inside the set", n_escaped, n_inside);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/jets_pkg.sv
hw/rtl/jets_cfg.sv
hw/rtl/jets_front.sv
hw/rtl/jets_queue.sv
hw/rtl/jets_back.sv
hw/rtl/julia_escape_time_pixel_top.sv
test/tb.sv
